// ===== rtl/core/satoi_pkg.sv =====
// satoi_pkg: widths, constants, codes and shared types of the swept box
// time-of-impact block. No dependencies; used by every rtl/core file except satoi_delay.
package satoi_pkg;

  // field and datapath widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned HALF_W  = 31;
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned NUM_W   = 35;
  localparam int unsigned RAD_W   = 66;
  localparam int unsigned ROOT_W  = 33;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned TOI_W   = 17;
  localparam int unsigned QUOT_W  = 25;
  localparam int unsigned TIME_W  = 26;

  // time constants in Q1.16 (TIME_ONE) and Q9.16 (TIME_SAT)
  localparam logic [TOI_W-1:0]  TIME_ONE = 17'h10000;
  localparam logic [QUOT_W-1:0] TIME_SAT = 25'h1000000;

  // register reset values
  localparam logic [CFG_W-1:0] MIN_MOTION_RST   = 16'd66;
  localparam logic [CFG_W-1:0] PARALLEL_EPS_RST = 16'd66;

  // configuration register indexes
  typedef enum logic {
    CFG_MIN_MOTION   = 1'b0,
    CFG_PARALLEL_EPS = 1'b1
  } cfg_index_t;

  // per-item data that rides beside the square root
  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic             out_x;
    logic             out_y;
  } side_t;

  // axis status once the motion length is known
  typedef struct packed {
    logic len_ok;
    logic par_x;
    logic par_y;
    logic out_x;
    logic out_y;
  } axis_flags_t;

endpackage

// ===== rtl/core/swept_aabb_time_of_impact.sv =====
// swept_aabb_time_of_impact: top level of the swept box slab test.
// Depends on satoi_pkg, satoi_delay, satoi_isqrt and satoi_fdiv.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one query word: old and new
//   centre of the moving box, target centre, and four scaled half extents.
//   Output channel (out_valid/out_ready) gives one word per query: hit and
//   toi (Q1.16, 65536 = 1.0, 0 on a miss), in query order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   min_motion (index 0) and parallel_eps (index 1); always ready; write
//   only while the block is idle.
// Timing:
//   One query per cycle while the output is not stalled. The 33 stage
//   square root is the deepest unit, with the slab dividers, one quotient
//   bit per stage, running alongside it.
// Reset and stall:
//   rst clears all valid bits and the output buffer and loads both
//   registers with 66. The pipeline holds when its last stage carries a
//   word and the two-entry output buffer is full and not being read; until
//   then new queries keep entering while finished words wait.
module swept_aabb_time_of_impact (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [satoi_pkg::COORD_W-1:0] old_x,
  input  logic signed [satoi_pkg::COORD_W-1:0] old_y,
  input  logic signed [satoi_pkg::COORD_W-1:0] new_x,
  input  logic signed [satoi_pkg::COORD_W-1:0] new_y,
  input  logic signed [satoi_pkg::COORD_W-1:0] target_x,
  input  logic signed [satoi_pkg::COORD_W-1:0] target_y,
  input  logic [satoi_pkg::HALF_W-1:0]         moving_half_w,
  input  logic [satoi_pkg::HALF_W-1:0]         moving_half_h,
  input  logic [satoi_pkg::HALF_W-1:0]         target_half_w,
  input  logic [satoi_pkg::HALF_W-1:0]         target_half_h,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic [satoi_pkg::TOI_W-1:0]          toi,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [satoi_pkg::CFG_W-1:0]          cfg_data
);

  localparam int unsigned CW     = satoi_pkg::COORD_W;
  localparam int unsigned DFW    = satoi_pkg::DIFF_W;
  localparam int unsigned NW     = satoi_pkg::NUM_W;
  localparam int unsigned MW     = satoi_pkg::MAG_W;
  localparam int unsigned TW     = satoi_pkg::TIME_W;
  localparam int unsigned QW     = satoi_pkg::ROOT_W;
  localparam int unsigned EPS_W  = satoi_pkg::CFG_W + 1;
  localparam int unsigned PROD_W = EPS_W + QW;
  localparam int unsigned LAT    = 42;
  localparam int unsigned SIDE_DLY = 35;
  localparam int unsigned DIV_DLY  = 10;
  localparam logic [1:0]  SKID_DEPTH = 2'd2;

  logic                    en;
  logic [LAT-1:0]          v;
  logic [satoi_pkg::CFG_W-1:0] min_motion;
  logic [satoi_pkg::CFG_W-1:0] parallel_eps;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_motion   <= satoi_pkg::MIN_MOTION_RST;
      parallel_eps <= satoi_pkg::PARALLEL_EPS_RST;
    end else if (cfg_valid) begin
      case (satoi_pkg::cfg_index_t'(cfg_index))
        satoi_pkg::CFG_MIN_MOTION:   min_motion   <= cfg_data;
        satoi_pkg::CFG_PARALLEL_EPS: parallel_eps <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits travel with the stages
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-2:0], in_valid};
    end
  end

  // stage 0: input word
  logic signed [CW-1:0]        s0_old_x, s0_old_y, s0_new_x, s0_new_y;
  logic signed [CW-1:0]        s0_target_x, s0_target_y;
  logic [satoi_pkg::HALF_W-1:0] s0_mhw, s0_mhh, s0_thw, s0_thh;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_old_x    <= old_x;
      s0_old_y    <= old_y;
      s0_new_x    <= new_x;
      s0_new_y    <= new_y;
      s0_target_x <= target_x;
      s0_target_y <= target_y;
      s0_mhw      <= moving_half_w;
      s0_mhh      <= moving_half_h;
      s0_thw      <= target_half_w;
      s0_thh      <= target_half_h;
    end
  end

  // stage 1: motion and slab bound distances
  logic [MW-1:0]         grow_x, grow_y;
  logic [NW-1:0]         tx_e, ty_e, ox_e, oy_e, gx_e, gy_e;
  logic signed [DFW-1:0] s1_dx, s1_dy;
  logic signed [NW-1:0]  s1_num [4];

  assign grow_x = MW'(s0_mhw) + MW'(s0_thw);
  assign grow_y = MW'(s0_mhh) + MW'(s0_thh);
  assign tx_e   = {{(NW-CW){s0_target_x[CW-1]}}, s0_target_x};
  assign ty_e   = {{(NW-CW){s0_target_y[CW-1]}}, s0_target_y};
  assign ox_e   = {{(NW-CW){s0_old_x[CW-1]}}, s0_old_x};
  assign oy_e   = {{(NW-CW){s0_old_y[CW-1]}}, s0_old_y};
  assign gx_e   = {{(NW-MW){1'b0}}, grow_x};
  assign gy_e   = {{(NW-MW){1'b0}}, grow_y};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx     <= {s0_new_x[CW-1], s0_new_x} - {s0_old_x[CW-1], s0_old_x};
      s1_dy     <= {s0_new_y[CW-1], s0_new_y} - {s0_old_y[CW-1], s0_old_y};
      s1_num[0] <= $signed(tx_e - gx_e - ox_e);
      s1_num[1] <= $signed(tx_e + gx_e - ox_e);
      s1_num[2] <= $signed(ty_e - gy_e - oy_e);
      s1_num[3] <= $signed(ty_e + gy_e - oy_e);
    end
  end

  // stage 2: motion magnitudes, start outside each grown slab
  satoi_pkg::side_t s2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side.ax    <= s1_dx[DFW-1] ? MW'(-s1_dx) : MW'(s1_dx);
      s2_side.ay    <= s1_dy[DFW-1] ? MW'(-s1_dy) : MW'(s1_dy);
      s2_side.out_x <= (!s1_num[0][NW-1] && (s1_num[0] != '0)) || s1_num[1][NW-1];
      s2_side.out_y <= (!s1_num[2][NW-1] && (s1_num[2] != '0)) || s1_num[3][NW-1];
    end
  end

  // stages 3 and 4: squared length
  logic [2*MW-1:0]              sqx_next, sqy_next;
  logic [2*MW-1:0]              s3_sqx, s3_sqy;
  logic [satoi_pkg::RAD_W-1:0]  s4_rad;

  assign sqx_next = s2_side.ax * s2_side.ax;
  assign sqy_next = s2_side.ay * s2_side.ay;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sqx <= sqx_next;
      s3_sqy <= sqy_next;
      s4_rad <= satoi_pkg::RAD_W'(s3_sqx) + satoi_pkg::RAD_W'(s3_sqy);
    end
  end

  // motion length
  logic [QW-1:0] len;

  satoi_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s4_rad),
    .root (len)
  );

  satoi_pkg::side_t side_d;

  satoi_delay #(
    .W ($bits(satoi_pkg::side_t)),
    .N (SIDE_DLY)
  ) u_side_dly (
    .clk (clk),
    .en  (en),
    .d   (s2_side),
    .q   (side_d)
  );

  // slab times, one divider per bound
  logic signed [TW-1:0] frac_raw [4];
  logic signed [TW-1:0] frac_d   [4];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    satoi_fdiv u_fdiv (
      .clk  (clk),
      .en   (en),
      .num  (s1_num[i]),
      .den  ((i < 2) ? s1_dx : s1_dy),
      .frac (frac_raw[i])
    );

    satoi_delay #(
      .W (TW),
      .N (DIV_DLY)
    ) u_frac_dly (
      .clk (clk),
      .en  (en),
      .d   (frac_raw[i]),
      .q   (frac_d[i])
    );
  end

  // stage 38: length checks and parallel axes
  logic [EPS_W-1:0]        eps1;
  logic [PROD_W-1:0]       prod_x, prod_y;
  satoi_pkg::axis_flags_t  f38;

  assign eps1   = {1'b0, parallel_eps} + EPS_W'(1);
  assign prod_x = eps1 * len;
  assign prod_y = eps1 * len;

  always_ff @(posedge clk) begin
    if (en) begin
      f38.len_ok <= (len != '0) && (len >= QW'(min_motion));
      f38.par_x  <= {{(PROD_W-MW-16){1'b0}}, side_d.ax, 16'b0} < prod_x;
      f38.par_y  <= {{(PROD_W-MW-16){1'b0}}, side_d.ay, 16'b0} < prod_y;
      f38.out_x  <= side_d.out_x;
      f38.out_y  <= side_d.out_y;
    end
  end

  // stage 39: entry and exit per axis
  logic signed [TW-1:0] en_x, ex_x, en_y, ex_y;
  logic                 miss39, par_x39, par_y39;

  always_ff @(posedge clk) begin
    if (en) begin
      en_x    <= (frac_d[0] < frac_d[1]) ? frac_d[0] : frac_d[1];
      ex_x    <= (frac_d[0] < frac_d[1]) ? frac_d[1] : frac_d[0];
      en_y    <= (frac_d[2] < frac_d[3]) ? frac_d[2] : frac_d[3];
      ex_y    <= (frac_d[2] < frac_d[3]) ? frac_d[3] : frac_d[2];
      miss39  <= !f38.len_ok || (f38.par_x && f38.out_x) || (f38.par_y && f38.out_y);
      par_x39 <= f38.par_x;
      par_y39 <= f38.par_y;
    end
  end

  // stage 40: overall interval
  logic signed [TW-1:0] tin_c, tout_c, tin, tout;
  logic                 miss40;

  always_comb begin
    tin_c  = '0;
    tout_c = $signed(TW'(satoi_pkg::TIME_ONE));
    if (!par_x39 && (en_x > tin_c)) begin
      tin_c = en_x;
    end
    if (!par_y39 && (en_y > tin_c)) begin
      tin_c = en_y;
    end
    if (!par_x39 && (ex_x < tout_c)) begin
      tout_c = ex_x;
    end
    if (!par_y39 && (ex_y < tout_c)) begin
      tout_c = ex_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tin    <= tin_c;
      tout   <= tout_c;
      miss40 <= miss39;
    end
  end

  // stage 41: result word
  logic                       hit41;
  logic [satoi_pkg::TOI_W-1:0] toi41;
  logic                       hit_c;

  assign hit_c = !miss40 && !(tin > tout) && !tout[TW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      hit41 <= hit_c;
      toi41 <= hit_c ? tin[satoi_pkg::TOI_W-1:0] : '0;
    end
  end

  // two-entry output buffer
  logic                        rbuf_hit [2];
  logic [satoi_pkg::TOI_W-1:0] rbuf_toi [2];
  logic                        wr_ptr, rd_ptr;
  logic [1:0]                  count, count_next;
  logic                        push, pop;

  assign en         = !v[LAT-1] || (count != SKID_DEPTH) || out_ready;
  assign push       = en && v[LAT-1];
  assign pop        = out_valid && out_ready;
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rbuf_hit[wr_ptr] <= hit41;
      rbuf_toi[wr_ptr] <= toi41;
    end
  end

  assign out_valid = (count != '0);
  assign hit       = rbuf_hit[rd_ptr];
  assign toi       = rbuf_toi[rd_ptr];

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= SKID_DEPTH)
    else $error("output buffer count overflow");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (toi == '0))
    else $error("miss word with nonzero toi");

  a_toi_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (toi <= satoi_pkg::TIME_ONE))
    else $error("toi above one");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ((count == SKID_DEPTH) && !out_ready) |-> !push)
    else $error("push into full output buffer");

endmodule

// ===== rtl/core/satoi_delay.sv =====
// satoi_delay: enabled shift line of fixed depth that keeps side data
// aligned with the pipelined units. No package dependency.
module satoi_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [N];

  // shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[N-1];

endmodule

// ===== rtl/core/satoi_isqrt.sv =====
// satoi_isqrt: pipelined floor square root of a 66 bit value, one root bit
// per stage, ROOT_W stages. Depends on satoi_pkg.
module satoi_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [satoi_pkg::RAD_W-1:0]   rad,
  output logic [satoi_pkg::ROOT_W-1:0]  root
);

  localparam int unsigned STEPS = satoi_pkg::ROOT_W;
  localparam int unsigned RW    = satoi_pkg::RAD_W;
  localparam int unsigned QW    = satoi_pkg::ROOT_W;
  localparam int unsigned REM_W = satoi_pkg::ROOT_W + 3;

  logic [RW-1:0]    rad_q  [STEPS-1];
  logic [REM_W-1:0] rem_q  [STEPS-1];
  logic [QW-1:0]    root_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int unsigned PB = 2 * (STEPS - 1 - k);
    logic [RW-1:0]    rad_in;
    logic [REM_W-1:0] rem_in;
    logic [QW-1:0]    root_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down the next bit pair and try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[PB+1:PB]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= {root_in[QW-2:0], take};
      end
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_q[k] <= rad_in;
          rem_q[k] <= take ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  assign root = root_q[STEPS-1];

endmodule

// ===== rtl/core/satoi_fdiv.sv =====
// satoi_fdiv: pipelined floor(num * 65536 / den), rounded toward minus
// infinity and saturated to +-2^24; one quotient bit per stage. Uses satoi_pkg.
module satoi_fdiv (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [satoi_pkg::NUM_W-1:0]  num,
  input  logic signed [satoi_pkg::DIFF_W-1:0] den,
  output logic signed [satoi_pkg::TIME_W-1:0] frac
);

  localparam int unsigned NW    = satoi_pkg::NUM_W;
  localparam int unsigned DW    = satoi_pkg::MAG_W;
  localparam int unsigned QW    = satoi_pkg::QUOT_W;
  localparam int unsigned TW    = satoi_pkg::TIME_W;
  localparam int unsigned FRAC  = 16;
  localparam int unsigned LOW_W = QW - FRAC;

  typedef struct packed {
    logic [LOW_W-1:0] low;
    logic [DW-1:0]    rem;
    logic [DW-1:0]    dv;
    logic [QW-1:0]    q;
    logic             neg;
    logic             ovf;
  } dstage_t;

  dstage_t       stg [QW+1];
  logic [NW-1:0] n_abs;
  logic [DW-1:0] d_abs;
  logic          ovf_a;

  // magnitudes, sign and overflow of the 25 bit quotient
  always_comb begin
    n_abs = num[NW-1] ? NW'(-num) : NW'(num);
    d_abs = den[satoi_pkg::DIFF_W-1] ? DW'(-den) : DW'(den);
    ovf_a = (DW'(n_abs[NW-1:LOW_W]) >= d_abs);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].low <= n_abs[LOW_W-1:0];
      stg[0].rem <= DW'(n_abs[NW-1:LOW_W]);
      stg[0].dv  <= d_abs;
      stg[0].q   <= '0;
      stg[0].neg <= num[NW-1] ^ den[satoi_pkg::DIFF_W-1];
      stg[0].ovf <= ovf_a;
    end
  end

  // restoring division, quotient bit QW-1 down to 0
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int unsigned QB = QW - 1 - k;
    logic          nb;
    logic [DW:0]   rem_sh;
    logic          take;

    if (QB >= FRAC) begin : g_low
      assign nb = stg[k].low[QB-FRAC];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign rem_sh = {stg[k].rem, nb};
    assign take   = (rem_sh >= {1'b0, stg[k].dv});

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k+1].low <= stg[k].low;
        stg[k+1].rem <= take ? DW'(rem_sh - {1'b0, stg[k].dv}) : DW'(rem_sh);
        stg[k+1].dv  <= stg[k].dv;
        stg[k+1].q   <= {stg[k].q[QW-2:0], take};
        stg[k+1].neg <= stg[k].neg;
        stg[k+1].ovf <= stg[k].ovf;
      end
    end
  end

  // saturate, round negative results down, apply sign
  logic          sat;
  logic [QW-1:0] qs;
  logic [TW-1:0] mag_e;

  always_comb begin
    sat = stg[QW].ovf || (stg[QW].q > satoi_pkg::TIME_SAT);
    qs  = sat ? satoi_pkg::TIME_SAT : stg[QW].q;
    if (stg[QW].neg && (stg[QW].rem != '0) && (qs < satoi_pkg::TIME_SAT)) begin
      qs = qs + QW'(1);
    end
    mag_e = {1'b0, qs};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac <= stg[QW].neg ? $signed(TW'(0) - mag_e) : $signed(mag_e);
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench of the swept box time-of-impact block.
// Depends on satoi_pkg and swept_aabb_time_of_impact; holds its own predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one query word
  typedef struct {
    logic signed [31:0] ox, oy, nx, ny, tx, ty;
    logic [30:0] mw, mh, tw, th;
  } query_t;

  // one result word
  typedef struct {
    logic        hit;
    logic [16:0] toi;
  } impact_t;

  // impact predictor and store of expected impacts
  class impact_board;
    logic [15:0] min_len;
    logic [15:0] par_eps;
    impact_t     pending[$];
    int          errors;

    function new();
      min_len = satoi_pkg::MIN_MOTION_RST;
      par_eps = satoi_pkg::PARALLEL_EPS_RST;
      errors  = 0;
    endfunction

    // floor sqrt of a 66 bit square sum
    function automatic logic [32:0] root66(logic [65:0] v);
      logic [67:0] rem;
      logic [67:0] trial;
      logic [32:0] r;
      rem = 0;
      r   = 0;
      for (int i = 32; i >= 0; i--) begin
        rem   = (rem << 2) | v[2*i +: 2];
        trial = ({35'd0, r} << 2) | 68'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          r   = (r << 1) | 33'd1;
        end else begin
          r = r << 1;
        end
      end
      return r;
    endfunction

    // slab time as a signed Q9.16 value, floored and saturated
    function automatic longint slab_time(longint num, longint den);
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] q;
      n = (num < 0 ? -num : num) << 16;
      d = den < 0 ? -den : den;
      q = n / d;
      if (q > 64'd16777216) q = 64'd16777216;
      if ((num < 0) != (den < 0)) begin
        if ((n % d) != 0 && q < 64'd16777216) q++;
        return -longint'(q);
      end
      return longint'(q);
    endfunction

    // returns 0 on a parallel axis miss
    function automatic bit axis(longint st, longint d, longint len, longint c, longint g,
                                inout longint tin, inout longint tout);
      longint lo, hi, q, s1, s2;
      lo = c - g;
      hi = c + g;
      q  = ((d < 0 ? -d : d) << 16) / len;
      if (q <= par_eps) return !(st < lo || st > hi);
      s1 = slab_time(lo - st, d);
      s2 = slab_time(hi - st, d);
      if ((s1 < s2 ? s1 : s2) > tin) tin = s1 < s2 ? s1 : s2;
      if ((s1 < s2 ? s2 : s1) < tout) tout = s1 < s2 ? s2 : s1;
      return 1;
    endfunction

    function void note_query(query_t w);
      longint dx, dy, len, tin, tout;
      logic [65:0] sq;
      impact_t e;
      bit h;
      dx  = longint'(w.nx) - longint'(w.ox);
      dy  = longint'(w.ny) - longint'(w.oy);
      sq  = 66'(dx < 0 ? -dx : dx) * 66'(dx < 0 ? -dx : dx)
          + 66'(dy < 0 ? -dy : dy) * 66'(dy < 0 ? -dy : dy);
      len  = longint'(root66(sq));
      tin  = 0;
      tout = 65536;
      h    = !(len == 0 || len < min_len);
      if (h) h = axis(w.ox, dx, len, w.tx, longint'(w.tw) + longint'(w.mw), tin, tout);
      if (h) h = axis(w.oy, dy, len, w.ty, longint'(w.th) + longint'(w.mh), tin, tout);
      if (h && (tin > tout || tout < 0)) h = 0;
      if (tin < 0) tin = 0;
      if (tin > 65536) tin = 65536;
      e.hit = h;
      e.toi = h ? 17'(tin) : 17'd0;
      pending = {pending, e};
    endfunction

    function void check_impact(logic h, logic [16:0] t);
      impact_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word hit=%0d toi=%0d", $time, h, t);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (h !== e.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, e.hit, h);
        errors++;
      end
      if (t !== e.toi) begin
        $display("%0t: toi expected %0d actual %0d", $time, e.toi, t);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, hit;
  logic signed [31:0] old_x, old_y, new_x, new_y, target_x, target_y;
  logic [30:0] moving_half_w, moving_half_h, target_half_w, target_half_h;
  logic [16:0] toi;
  logic cfg_valid, cfg_ready;
  satoi_pkg::cfg_index_t cfg_index;
  logic [15:0] cfg_data;

  impact_board board;
  bit long_hold;

  swept_aabb_time_of_impact DUT (
    .clk, .rst, .in_valid, .in_ready, .old_x, .old_y, .new_x, .new_y,
    .target_x, .target_y, .moving_half_w, .moving_half_h, .target_half_w,
    .target_half_h, .out_valid, .out_ready, .hit, .toi, .cfg_valid, .cfg_ready,
    .cfg_index(cfg_index), .cfg_data
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("swept_aabb_time_of_impact verification failed");
    $finish;
  end

  // receiver: stalls in a pattern of its own, with one long hold
  initial begin
    int mode;
    out_ready = 0;
    mode      = 0;
    forever begin
      @(negedge clk);
      if (long_hold) out_ready <= 0;
      else if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (!long_hold) begin
        case (mode)
          0: out_ready <= 1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_impact(hit, toi);
  end

  // drive one query word, waiting for acceptance
  task automatic send_query(query_t w);
    in_valid      <= 1;
    old_x         <= w.ox;
    old_y         <= w.oy;
    new_x         <= w.nx;
    new_y         <= w.ny;
    target_x      <= w.tx;
    target_y      <= w.ty;
    moving_half_w <= w.mw;
    moving_half_h <= w.mh;
    target_half_w <= w.tw;
    target_half_h <= w.th;
    do @(posedge clk); while (!in_ready);
    board.note_query(w);
    @(negedge clk);
  endtask

  // sender gap between bursts
  task automatic gap_or_burst(inout int left);
    int g;
    if (left > 0) begin
      left--;
      return;
    end
    left = $urandom_range(0, 12);
    g    = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(satoi_pkg::cfg_index_t idx, logic [15:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == satoi_pkg::CFG_MIN_MOTION) board.min_len = v;
    else board.par_eps = v;
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 2000000)) - 1000000;
      default: return $signed($urandom_range(0, 60000)) - 30000;
    endcase
  endfunction

  function automatic logic [30:0] rand_half(int kind);
    case (kind)
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 400000));
      default: return 31'($urandom_range(0, 20000));
    endcase
  endfunction

  // random query: mostly aimed at the target, some noise
  function automatic query_t rand_query();
    query_t w;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      w.ox = rand_coord(0); w.oy = rand_coord(0); w.nx = rand_coord(0);
      w.ny = rand_coord(0); w.tx = rand_coord(0); w.ty = rand_coord(0);
      w.mw = rand_half(0); w.mh = rand_half(0); w.tw = rand_half(0);
      w.th = rand_half(0);
    end else begin
      k = k < 5 ? 1 : 2;
      w.tx = rand_coord(k);
      w.ty = rand_coord(k);
      w.mw = rand_half(k); w.mh = rand_half(k);
      w.tw = rand_half(k); w.th = rand_half(k);
      w.ox = w.tx + rand_coord(k) * 2;
      w.oy = w.ty + rand_coord(k) * 2;
      case ($urandom_range(0, 3))
        0: begin w.nx = w.tx + rand_coord(k); w.ny = w.ty + rand_coord(k); end
        1: begin w.nx = w.tx - (w.ox - w.tx); w.ny = w.oy + $signed($urandom_range(0, 40)) - 20; end
        2: begin w.nx = w.ox + $signed($urandom_range(0, 40)) - 20; w.ny = w.ty - (w.oy - w.ty); end
        default: begin w.nx = w.ox + $signed($urandom_range(0, 200)) - 100;
                       w.ny = w.oy + $signed($urandom_range(0, 200)) - 100; end
      endcase
    end
    return w;
  endfunction

  function automatic query_t make_query(logic [31:0] ox, oy, nx, ny, tx, ty,
                                        logic [30:0] mw, mh, tw, th);
    query_t w;
    w.ox = ox; w.oy = oy; w.nx = nx; w.ny = ny; w.tx = tx; w.ty = ty;
    w.mw = mw; w.mh = mh; w.tw = tw; w.th = th;
    return w;
  endfunction

  // main stimulus
  initial begin
    query_t w;
    int left;
    logic [15:0] settings[5][2] = '{'{16'd66, 16'd66}, '{16'd0, 16'd0},
                                    '{16'hFFFF, 16'hFFFF}, '{16'd1000, 16'd20000},
                                    '{16'd66, 16'd66}};
    board = new();
    rst = 1;
    in_valid = 0; cfg_valid = 0; cfg_index = satoi_pkg::CFG_MIN_MOTION; cfg_data = 0;
    old_x = 0; old_y = 0; new_x = 0; new_y = 0; target_x = 0; target_y = 0;
    moving_half_w = 0; moving_half_h = 0; target_half_w = 0; target_half_h = 0;
    long_hold = 0; left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: zero, short, parallel, extremes, head-on
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(0, 0, 10, 0, 100, 0, 5, 5, 5, 5));
    send_query(make_query(-200000, 0, 200000, 0, 0, 0, 1000, 1000, 1000, 1000));
    send_query(make_query(0, -200000, 0, 200000, 0, 0, 1000, 1000, 1000, 1000));
    send_query(make_query(-200000, 50000, 200000, 50000, 0, 0, 1000, 1000, 1000, 1000));
    send_query(make_query(-200000, -200000, 200000, 200000, 0, 0, 500, 500, 500, 500));
    send_query(make_query(0, 0, 100000, 100, 0, 0, 3000, 3000, 3000, 3000));
    send_query(make_query(200000, 0, 300000, 0, 0, 0, 1000, 1000, 1000, 1000));
    send_query(make_query(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF));
    send_query(make_query(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0));
    send_query(make_query(32'h80000000, 0, 32'h7FFFFFFF, 1, 0, 0, 1, 1, 1, 1));
    send_query(make_query(-100, 0, 100, 0, 0, 0, 31'h7FFFFFFF, 0, 31'h7FFFFFFF, 0));
    send_query(make_query(-65536, 0, 65536, 0, 65536, 0, 0, 0, 0, 0));
    send_query(make_query(1000, 1000, 2000, 1000, 0, 0, 500, 500, 500, 500));
    send_query(make_query(0, 0, 70, 0, 0, 0, 0, 0, 0, 0));

    // random phases through several register settings
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(satoi_pkg::CFG_MIN_MOTION, settings[p][0]);
      write_reg(satoi_pkg::CFG_PARALLEL_EPS, settings[p][1]);
      for (int i = 0; i < 90; i++) begin
        // long receiver hold while the sender keeps offering words
        if (p == 1 && i == 10) begin
          long_hold = 1;
          fork
            begin
              repeat (200) @(negedge clk);
              long_hold = 0;
            end
          join_none
        end
        // sender pauses until every expected word has come
        if (p == 2 && i == 45) begin
          in_valid <= 0;
          while (board.pending.size() != 0) @(negedge clk);
        end
        gap_or_burst(left);
        send_query(rand_query());
      end
    end

    drain();
    if (board.errors == 0) $display("swept_aabb_time_of_impact verification clean");
    else $display("swept_aabb_time_of_impact verification failed");
    $finish;
  end
endmodule
